>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

>>> hdl/wcb_pkg.sv
// ----------------------------------------------------------------------------
// wcb_pkg
// Constants, widths and codes of the color wheel with brightness levels.
// ----------------------------------------------------------------------------
`default_nettype none

package wcb_pkg;

  // Wheel geometry
  localparam int LEVEL_COUNT       = 4;
  localparam int COLORS_PER_LEVEL  = 63;
  localparam int RAMP_SPAN         = 21;
  localparam int MIDDLE_LEVEL      = 2;

  // Field widths
  localparam int COLOR_W   = 8;
  localparam int SEG_W     = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [COLOR_W-1:0] WHITE_VALUE = 8'd255;

  // Level split: v / C by reciprocal, one correction step
  localparam int HUE_SHIFT = 8;
  localparam int HUE_RECIP = (1 << HUE_SHIFT) / COLORS_PER_LEVEL;
  localparam int B_W       = 7;   // level is at most 254 / 63
  localparam int HP_W      = 16;

  // Ramp slope
  localparam int RAMP_K = 3 * LEVEL_COUNT;

  // Scaling factors and their exact division
  localparam int F_W         = 14;
  localparam int MAG_W       = COLOR_W + F_W;
  localparam int LIGHT_DEN   = LEVEL_COUNT * LEVEL_COUNT;
  localparam int DARK_DEN    = (MIDDLE_LEVEL + 1) * (MIDDLE_LEVEL + 1);
  localparam int RECIP_W     = MAG_W + 1;
  localparam int LIGHT_RECIP = (1 << MAG_W) / LIGHT_DEN;
  localparam int DARK_RECIP  = (1 << MAG_W) / DARK_DEN;
  localparam int PROD_W      = MAG_W + RECIP_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_RED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_GREEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_BLUE  = 2'd2;

  // Level treatment
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_KEEP  = 2'd0;
  localparam mode_t MODE_LIGHT = 2'd1;
  localparam mode_t MODE_DARK  = 2'd2;

  typedef logic [COLOR_W-1:0] color_t;

endpackage

`default_nettype wire

>>> hdl/wheel_color_with_brightness.sv
// ----------------------------------------------------------------------------
// wheel_color_with_brightness
// Maps an 8-bit wheel value to an RGB color with brightness levels.
// ----------------------------------------------------------------------------
// Usage: one wheel value enters per clock while in_stall is low, and its color
// leaves through six register stages, the last one being the output register. The
// pipeline is fully streaming: a new item can be taken in every cycle, and
// when the output side stalls, the stall only reaches the input once every
// stage holds an item, so bubbles are squeezed out first. Wheel value 255
// returns the white color held in the three white registers (reset 255).
// Any other value splits into a hue (value mod colors per level) and a level
// (value / colors per level); the hue walks one of three ramps, and the level
// mixes toward white above the middle level or darkens below it. Write the
// white registers only while the pipeline is empty.
// Stages: 1 level estimate, 2 level correction and hue, 3 ramp and level
// factor, 4 scale product, 5 quotient estimate, 6 quotient fix and output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module wheel_color_with_brightness
  import wcb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // configuration
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COLOR_W-1:0]   cfg_data,
  // input channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [COLOR_W-1:0]   wheel_code,
  input  wire logic [SEG_W-1:0]     segment_index,
  // output channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [COLOR_W-1:0]        red_out,
  output logic [COLOR_W-1:0]        green_out,
  output logic [COLOR_W-1:0]        blue_out,
  output logic [SEG_W-1:0]          segment_out
);

  // --------------------------------------------------------------------------
  // White registers
  // --------------------------------------------------------------------------
  logic [COLOR_W-1:0] white_red;
  logic [COLOR_W-1:0] white_green;
  logic [COLOR_W-1:0] white_blue;
  color_t             white_c [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      white_red   <= WHITE_VALUE;
      white_green <= WHITE_VALUE;
      white_blue  <= WHITE_VALUE;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WHITE_RED:   white_red   <= cfg_data;
        REG_WHITE_GREEN: white_green <= cfg_data;
        REG_WHITE_BLUE:  white_blue  <= cfg_data;
        default: ;       // drop writes to unused indexes
      endcase
    end
  end

  assign white_c[0] = white_red;
  assign white_c[1] = white_green;
  assign white_c[2] = white_blue;

  // --------------------------------------------------------------------------
  // Stage valids and load enables. A stage loads when it is empty or when
  // the stage after it loads too; the output register loads when the
  // transfer on the output side completes or it is empty.
  // --------------------------------------------------------------------------
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid, s6_valid;
  logic ld1, ld2, ld3, ld4, ld5, ld6;

  assign ld6 = !s6_valid || !out_stall;
  assign ld5 = !s5_valid || ld6;
  assign ld4 = !s4_valid || ld5;
  assign ld3 = !s3_valid || ld4;
  assign ld2 = !s2_valid || ld3;
  assign ld1 = !s1_valid || ld2;

  assign in_stall = !ld1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
    end else begin
      if (ld1) s1_valid <= in_valid;
      if (ld2) s2_valid <= s1_valid;
      if (ld3) s3_valid <= s2_valid;
      if (ld4) s4_valid <= s3_valid;
      if (ld5) s5_valid <= s4_valid;
      if (ld6) s6_valid <= s5_valid;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: level estimate, value * floor(256/C) >> 8. It is either the
  // true quotient or one short of it.
  // --------------------------------------------------------------------------
  logic [HP_W-1:0]    hue_prod;
  logic [COLOR_W-1:0] s1_value;
  logic [SEG_W-1:0]   s1_seg;
  logic [B_W-1:0]     s1_qest;

  assign hue_prod = HP_W'(wheel_code) * HP_W'(HUE_RECIP);

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_value <= wheel_code;
      s1_seg   <= segment_index;
      s1_qest  <= hue_prod[HUE_SHIFT +: B_W];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: fix the level by one compare and subtract, giving hue and level
  // --------------------------------------------------------------------------
  logic [COLOR_W:0]   hue_rem;
  logic               hue_ge;
  logic [COLOR_W-1:0] s2_hue;
  logic [B_W-1:0]     s2_level;
  logic               s2_white;
  logic [SEG_W-1:0]   s2_seg;

  always_comb begin
    hue_rem = {1'b0, s1_value} - (COLOR_W+1)'(s1_qest * COLOR_W'(COLORS_PER_LEVEL));
    hue_ge  = hue_rem >= (COLOR_W+1)'(COLORS_PER_LEVEL);
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      s2_hue   <= hue_ge ? COLOR_W'(hue_rem - (COLOR_W+1)'(COLORS_PER_LEVEL))
                         : hue_rem[COLOR_W-1:0];
      s2_level <= s1_qest + B_W'(hue_ge);
      s2_white <= (s1_value == WHITE_VALUE);
      s2_seg   <= s1_seg;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: hue ramp (at most 240, no wrap) and level factor, b^2 when lightening
  // or (b+1)^2 when darkening
  // --------------------------------------------------------------------------
  color_t         ramp;
  color_t         color_n [3];
  mode_t          mode_n;
  logic [B_W-1:0] level_sel;
  color_t         s3_color [3];
  mode_t          s3_mode;
  logic [F_W-1:0] s3_factor;
  logic [SEG_W-1:0] s3_seg;

  always_comb begin
    if (s2_hue < COLOR_W'(RAMP_SPAN)) begin
      ramp       = s2_hue * COLOR_W'(RAMP_K);
      color_n[0] = ~ramp;
      color_n[1] = ramp;
      color_n[2] = '0;
    end else if (s2_hue < COLOR_W'(2 * RAMP_SPAN)) begin
      ramp       = (s2_hue - COLOR_W'(RAMP_SPAN)) * COLOR_W'(RAMP_K);
      color_n[0] = '0;
      color_n[1] = ~ramp;
      color_n[2] = ramp;
    end else begin
      ramp       = (s2_hue - COLOR_W'(2 * RAMP_SPAN)) * COLOR_W'(RAMP_K);
      color_n[0] = ramp;
      color_n[1] = '0;
      color_n[2] = ~ramp;
    end

    mode_n = MODE_KEEP;
    if (LEVEL_COUNT > 1) begin
      if (s2_level > B_W'(MIDDLE_LEVEL)) begin
        mode_n = MODE_LIGHT;
      end else if (s2_level < B_W'(MIDDLE_LEVEL)) begin
        mode_n = MODE_DARK;
      end
    end

    // White overrides the ramp and skips the level treatment
    if (s2_white) begin
      color_n[0] = white_red;
      color_n[1] = white_green;
      color_n[2] = white_blue;
      mode_n     = MODE_KEEP;
    end

    level_sel = (mode_n == MODE_DARK) ? s2_level + B_W'(1) : s2_level;
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      for (int i = 0; i < 3; i++) begin
        s3_color[i] <= color_n[i];
      end
      s3_mode   <= mode_n;
      s3_factor <= F_W'(level_sel) * F_W'(level_sel);
      s3_seg    <= s2_seg;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: scale product. Lightening takes |c - white| * b^2 with its sign
  // kept apart; darkening takes c * (b+1)^2.
  // --------------------------------------------------------------------------
  color_t           abs_diff [3];
  logic             neg_n    [3];
  color_t           s4_color [3];
  logic [MAG_W-1:0] s4_mag   [3];
  logic             s4_neg   [3];
  mode_t            s4_mode;
  logic [SEG_W-1:0] s4_seg;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (s3_mode == MODE_LIGHT) begin
        neg_n[i]    = s3_color[i] < white_c[i];
        abs_diff[i] = neg_n[i] ? white_c[i] - s3_color[i] : s3_color[i] - white_c[i];
      end else begin
        neg_n[i]    = 1'b0;
        abs_diff[i] = s3_color[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld4) begin
      for (int i = 0; i < 3; i++) begin
        s4_color[i] <= s3_color[i];
        s4_mag[i]   <= MAG_W'(abs_diff[i]) * MAG_W'(s3_factor);
        s4_neg[i]   <= neg_n[i];
      end
      s4_mode <= s3_mode;
      s4_seg  <= s3_seg;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: quotient estimate, mag * floor(2^MAG_W / den) >> MAG_W
  // --------------------------------------------------------------------------
  logic [RECIP_W-1:0] recip;
  logic [PROD_W-1:0]  quot_prod [3];
  color_t             s5_color  [3];
  logic [MAG_W-1:0]   s5_mag    [3];
  logic [MAG_W-1:0]   s5_qest   [3];
  logic               s5_neg    [3];
  mode_t              s5_mode;
  logic [SEG_W-1:0]   s5_seg;

  always_comb begin
    recip = (s4_mode == MODE_LIGHT) ? RECIP_W'(LIGHT_RECIP) : RECIP_W'(DARK_RECIP);
    for (int i = 0; i < 3; i++) begin
      quot_prod[i] = PROD_W'(s4_mag[i]) * PROD_W'(recip);
    end
  end

  always_ff @(posedge clk) begin
    if (ld5) begin
      for (int i = 0; i < 3; i++) begin
        s5_color[i] <= s4_color[i];
        s5_mag[i]   <= s4_mag[i];
        s5_qest[i]  <= quot_prod[i][MAG_W +: MAG_W];
        s5_neg[i]   <= s4_neg[i];
      end
      s5_mode <= s4_mode;
      s5_seg  <= s4_seg;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: fix the quotient by one step and form the output color
  // --------------------------------------------------------------------------
  logic [MAG_W-1:0] den;
  logic [MAG_W-1:0] quot_rem [3];
  logic             quot_ge  [3];
  color_t           quot8    [3];
  color_t           result_n [3];
  logic             rem_ok;
  color_t           s6_color [3];
  logic [SEG_W-1:0] s6_seg;

  always_comb begin
    den    = (s5_mode == MODE_LIGHT) ? MAG_W'(LIGHT_DEN) : MAG_W'(DARK_DEN);
    rem_ok = 1'b1;
    for (int i = 0; i < 3; i++) begin
      quot_rem[i] = s5_mag[i] - s5_qest[i] * den;
      quot_ge[i]  = quot_rem[i] >= den;
      quot8[i]    = s5_qest[i][COLOR_W-1:0] + COLOR_W'(quot_ge[i]);
      rem_ok      = rem_ok && (quot_rem[i] < (den << 1));
      case (s5_mode)
        MODE_LIGHT: result_n[i] = s5_neg[i] ? s5_color[i] + quot8[i]
                                            : s5_color[i] - quot8[i];
        MODE_DARK:  result_n[i] = quot8[i];
        default:    result_n[i] = s5_color[i];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ld6) begin
      for (int i = 0; i < 3; i++) begin
        s6_color[i] <= result_n[i];
      end
      s6_seg <= s5_seg;
    end
  end

  assign out_valid   = s6_valid;
  assign red_out     = s6_color[0];
  assign green_out   = s6_color[1];
  assign blue_out    = s6_color[2];
  assign segment_out = s6_seg;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASSERT_NEXT(a_accept_lands, clk, rst, in_valid && !in_stall, s1_valid, "accepted item lost at stage 1")
  `ASSERT_IMPLY(a_stall_full, clk, rst, in_stall, s1_valid && s2_valid && s3_valid && s4_valid && s5_valid && s6_valid && out_stall, "input stalled with a free stage")
  `ASSERT_IMPLY(a_hue_range, clk, rst, s2_valid, s2_hue < COLOR_W'(COLORS_PER_LEVEL), "hue not below colors per level")
  `ASSERT_IMPLY(a_quot_step, clk, rst, s5_valid && s5_mode != MODE_KEEP, rem_ok, "quotient estimate off by more than one")

endmodule

`default_nettype wire
